>>> sv/hbfa_pkg.sv
// shared constants, types and helpers of the harmonic bond force accumulator
// no dependencies
package hbfa_pkg;

  localparam int PARTICLES_DEF = 1024;
  localparam int IDXW = 10;
  localparam int POSW = 32;
  localparam int CFGW = 32;
  localparam int DW = POSW + 1;
  localparam int FORCEW = 48;
  localparam int ENW = 48;
  localparam int MAGW = 49;
  localparam int PRODW = 82;
  localparam int SUMW = 66;
  localparam int ROOTW = 33;
  localparam int MULW = 33;
  localparam int SQW = 33;
  localparam int DIVW = 82;
  localparam int CNTW = 7;
  localparam int WORDW = 3 * FORCEW;
  localparam int IDXXW = 17;

  typedef enum logic [1:0] {
    CMD_BOND   = 2'd0,
    CMD_FORCE  = 2'd1,
    CMD_ENERGY = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    CS_IDLE, CS_SQ, CS_ROOT, CS_RSUB, CS_KR, CS_EN, CS_FM, CS_FD, CS_DONE
  } core_state_e;

  typedef enum logic [2:0] {
    TS_CLEAR, TS_IDLE, TS_BOND, TS_RD1, TS_WR1, TS_RD2, TS_WR2, TS_FRD
  } top_state_e;

  typedef logic [MAGW-1:0] fmag_t;

  typedef struct packed {
    fmag_t [2:0]    mag;
    logic  [2:0]    neg;
    logic [ENW-1:0] energy;
  } bond_res_t;

  function automatic logic [FORCEW-1:0] sat_acc(logic [FORCEW-1:0] old, fmag_t m, logic sub);
    logic [FORCEW+2:0] a;
    logic [FORCEW+2:0] b;
    logic [FORCEW+2:0] s;
    a = {{3{old[FORCEW-1]}}, old};
    b = {2'b00, m};
    s = sub ? a - b : a + b;
    if (s[FORCEW+2:FORCEW-1] == {4{s[FORCEW-1]}}) begin
      sat_acc = s[FORCEW-1:0];
    end else if (s[FORCEW+2]) begin
      sat_acc = {1'b1, {(FORCEW-1){1'b0}}};
    end else begin
      sat_acc = {1'b0, {(FORCEW-1){1'b1}}};
    end
  endfunction

endpackage

>>> sv/hbfa_store.sv
// force store: one synchronous memory word per particle holding x, y, z
// depends on hbfa_pkg
module hbfa_store import hbfa_pkg::*; #(
  parameter int DEPTH = PARTICLES_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WORDW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WORDW-1:0] rdata_o
);

  logic [WORDW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> sv/hbfa_core.sv
// bond arithmetic: shift-add multiplier, bitwise square root and restoring divider
// sequenced by one controller; depends on hbfa_pkg
module hbfa_core import hbfa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [POSW-1:0] first_x_i,
  input  logic [POSW-1:0] first_y_i,
  input  logic [POSW-1:0] first_z_i,
  input  logic [POSW-1:0] second_x_i,
  input  logic [POSW-1:0] second_y_i,
  input  logic [POSW-1:0] second_z_i,
  input  logic [CFGW-1:0] spring_constant_i,
  input  logic [CFGW-1:0] rest_length_i,
  output logic            done_o,
  output bond_res_t       res_o
);

  core_state_e state_q, state_d;

  logic [DW-1:0]    dmag_q [3];
  logic [2:0]       dneg_q;
  logic [1:0]       c_q;
  logic [CNTW-1:0]  cnt_q;
  logic [PRODW-1:0] mc_q;
  logic [MULW-1:0]  mr_q;
  logic [PRODW-1:0] prod_q;
  logic [SUMW-1:0]  sum_q;
  logic [ROOTW+1:0] rem_q;
  logic [ROOTW-1:0] root_q;
  logic             rneg_q;
  logic [ROOTW-1:0] rmag_q;
  fmag_t            p_q;
  logic [ROOTW-1:0] drem_q;
  fmag_t            quo_q;
  bond_res_t        res_q;

  logic [DW-1:0]    din [3];
  logic [DW-1:0]    dinmag [3];
  logic [PRODW-1:0] mul_acc;
  logic             last_mul, last_root, last_div;
  logic [ROOTW+3:0] rt, rtrial;
  logic             rge;
  logic [ROOTW+1:0] rem_d;
  logic [ROOTW-1:0] root_d;
  logic [ROOTW:0]   dt;
  logic             dge;
  logic [ROOTW-1:0] drem_d;
  fmag_t            quo_d;
  logic [ROOTW:0]   r_s;
  logic [ROOTW-1:0] r_mag;
  logic [1:0]       c_nx;

  assign din[0] = {first_x_i[POSW-1], first_x_i} - {second_x_i[POSW-1], second_x_i};
  assign din[1] = {first_y_i[POSW-1], first_y_i} - {second_y_i[POSW-1], second_y_i};
  assign din[2] = {first_z_i[POSW-1], first_z_i} - {second_z_i[POSW-1], second_z_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dinmag[i] = din[i][DW-1] ? DW'(-din[i]) : din[i];
    end
  end

  assign c_nx      = c_q + 2'd1;
  assign mul_acc   = prod_q + (mr_q[0] ? mc_q : '0);
  assign last_mul  = cnt_q == CNTW'(MULW - 1);
  assign last_root = cnt_q == CNTW'(SQW - 1);
  assign last_div  = cnt_q == CNTW'(DIVW - 1);

  assign rt     = {rem_q, sum_q[SUMW-1:SUMW-2]};
  assign rtrial = {2'b00, root_q, 2'b01};
  assign rge    = rt >= rtrial;
  assign rem_d  = rge ? (ROOTW+2)'(rt - rtrial) : rt[ROOTW+1:0];
  assign root_d = {root_q[ROOTW-2:0], rge};

  assign dt     = {drem_q, prod_q[PRODW-1]};
  assign dge    = dt >= {1'b0, root_q};
  assign drem_d = dge ? ROOTW'(dt - {1'b0, root_q}) : dt[ROOTW-1:0];
  assign quo_d  = {quo_q[MAGW-2:0], dge};

  assign r_s   = {1'b0, root_q} - {2'b00, rest_length_i};
  assign r_mag = r_s[ROOTW] ? ROOTW'(-r_s) : r_s[ROOTW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: if (start_i) state_d = CS_SQ;
      CS_SQ:   if (last_mul && c_q == 2'd2) state_d = CS_ROOT;
      CS_ROOT: if (last_root) state_d = CS_RSUB;
      CS_RSUB: state_d = CS_KR;
      CS_KR:   if (last_mul) state_d = CS_EN;
      CS_EN: begin
        if (last_mul) state_d = (root_q == '0) ? CS_DONE : CS_FM;
      end
      CS_FM:   if (last_mul) state_d = CS_FD;
      CS_FD: begin
        if (last_div) state_d = (c_q == 2'd2) ? CS_DONE : CS_FM;
      end
      CS_DONE: state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_o = state_q == CS_DONE;
    res_o  = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            dmag_q[i] <= dinmag[i];
            dneg_q[i] <= din[i][DW-1];
          end
          c_q        <= '0;
          cnt_q      <= '0;
          sum_q      <= '0;
          mc_q       <= PRODW'(dinmag[0]);
          mr_q       <= dinmag[0];
          prod_q     <= '0;
          res_q.mag  <= '0;
          res_q.neg  <= '0;
        end
      end
      CS_SQ: begin
        prod_q <= mul_acc;
        mc_q   <= {mc_q[PRODW-2:0], 1'b0};
        mr_q   <= {1'b0, mr_q[MULW-1:1]};
        cnt_q  <= cnt_q + 1'b1;
        if (last_mul) begin
          sum_q <= sum_q + mul_acc[SUMW-1:0];
          cnt_q <= '0;
          if (c_q == 2'd2) begin
            rem_q  <= '0;
            root_q <= '0;
          end else begin
            c_q    <= c_nx;
            mc_q   <= PRODW'(dmag_q[c_nx]);
            mr_q   <= dmag_q[c_nx];
            prod_q <= '0;
          end
        end
      end
      CS_ROOT: begin
        rem_q  <= rem_d;
        root_q <= root_d;
        sum_q  <= {sum_q[SUMW-3:0], 2'b00};
        cnt_q  <= last_root ? '0 : cnt_q + 1'b1;
      end
      CS_RSUB: begin
        rneg_q <= r_s[ROOTW];
        rmag_q <= r_mag;
        mc_q   <= PRODW'(spring_constant_i);
        mr_q   <= r_mag;
        prod_q <= '0;
        cnt_q  <= '0;
      end
      CS_KR: begin
        prod_q <= mul_acc;
        mc_q   <= {mc_q[PRODW-2:0], 1'b0};
        mr_q   <= {1'b0, mr_q[MULW-1:1]};
        cnt_q  <= cnt_q + 1'b1;
        if (last_mul) begin
          p_q    <= mul_acc[MAGW+15:16];
          mc_q   <= PRODW'(mul_acc[MAGW+15:16]);
          mr_q   <= rmag_q;
          prod_q <= '0;
          cnt_q  <= '0;
        end
      end
      CS_EN: begin
        prod_q <= mul_acc;
        mc_q   <= {mc_q[PRODW-2:0], 1'b0};
        mr_q   <= {1'b0, mr_q[MULW-1:1]};
        cnt_q  <= cnt_q + 1'b1;
        if (last_mul) begin
          res_q.energy <= (mul_acc[PRODW-1:ENW+17] != '0) ? '1 : mul_acc[ENW+16:17];
          c_q    <= '0;
          mc_q   <= PRODW'(p_q);
          mr_q   <= dmag_q[0];
          prod_q <= '0;
          cnt_q  <= '0;
        end
      end
      CS_FM: begin
        prod_q <= mul_acc;
        mc_q   <= {mc_q[PRODW-2:0], 1'b0};
        mr_q   <= {1'b0, mr_q[MULW-1:1]};
        cnt_q  <= cnt_q + 1'b1;
        if (last_mul) begin
          drem_q <= '0;
          quo_q  <= '0;
          cnt_q  <= '0;
        end
      end
      CS_FD: begin
        prod_q <= {prod_q[PRODW-2:0], 1'b0};
        drem_q <= drem_d;
        quo_q  <= quo_d;
        cnt_q  <= cnt_q + 1'b1;
        if (last_div) begin
          res_q.mag[c_q] <= quo_d;
          res_q.neg[c_q] <= rneg_q == dneg_q[c_q];
          cnt_q <= '0;
          if (c_q != 2'd2) begin
            c_q    <= c_nx;
            mc_q   <= PRODW'(p_q);
            mr_q   <= dmag_q[c_nx];
            prod_q <= '0;
          end
        end
      end
      CS_DONE: ;
      default: ;
    endcase
  end

endmodule

>>> sv/harmonic_bond_force_accumulator.sv
// harmonic bond force accumulator: add bond runs the shared bit-serial multiplier, square
// root and divider loops, then two read-modify-write passes on the force memory (the force
// multiply and divide steps are skipped when the distance is zero)
// force read: store read on start, result registered in TS_FRD; energy read: result in the
// cycle after start; after reset the force memory is cleared one entry a cycle, busy high
// results are strobed for one cycle and cannot be stalled; depends on hbfa_pkg, core, store
module harmonic_bond_force_accumulator import hbfa_pkg::*; #(
  parameter int PARTICLES = PARTICLES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command_i,
  input  logic [IDXW-1:0]   first_index_i,
  input  logic [IDXW-1:0]   second_index_i,
  input  logic [POSW-1:0]   first_x_i,
  input  logic [POSW-1:0]   first_y_i,
  input  logic [POSW-1:0]   first_z_i,
  input  logic [POSW-1:0]   second_x_i,
  input  logic [POSW-1:0]   second_y_i,
  input  logic [POSW-1:0]   second_z_i,
  output logic              result_valid_o,
  output logic [IDXW-1:0]   particle_index_o,
  output logic [FORCEW-1:0] force_x_o,
  output logic [FORCEW-1:0] force_y_o,
  output logic [FORCEW-1:0] force_z_o,
  output logic [ENW-1:0]    total_energy_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = $clog2(PARTICLES);

  top_state_e state_q, state_d;

  logic [CFGW-1:0]   k_q, rest_q;
  logic [ENW-1:0]    energy_q;
  logic [AW-1:0]     clr_q;
  logic              valid_q;
  logic [IDXW-1:0]   idx1_q, idx2_q;
  logic [IDXW-1:0]   pidx_q;
  logic [FORCEW-1:0] fx_q, fy_q, fz_q;
  logic [ENW-1:0]    eout_q;

  logic              accept, core_start, core_done;
  bond_res_t         core_res;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORDW-1:0]  mem_wdata, mem_rdata;
  logic              in_rng_a, in_rng_1, in_rng_2;
  logic [AW-1:0]     addr_a, addr_1, addr_2;
  logic [IDXXW-1:0]  ext_a, ext_1, ext_2;
  logic [ENW:0]      en_sum;
  logic              cmd_is_bond;
  logic              sub_sel;
  logic [WORDW-1:0]  upd_word;

  assign accept      = start && !busy;
  assign cmd_is_bond = command_i == CMD_BOND;
  assign core_start  = accept && cmd_is_bond;

  assign ext_a    = IDXXW'(first_index_i);
  assign ext_1    = IDXXW'(idx1_q);
  assign ext_2    = IDXXW'(idx2_q);
  assign in_rng_a = ext_a < IDXXW'(PARTICLES);
  assign in_rng_1 = ext_1 < IDXXW'(PARTICLES);
  assign in_rng_2 = ext_2 < IDXXW'(PARTICLES);
  assign addr_a   = ext_a[AW-1:0];
  assign addr_1   = ext_1[AW-1:0];
  assign addr_2   = ext_2[AW-1:0];

  assign en_sum = {1'b0, energy_q} + {1'b0, core_res.energy};

  // first particle gets +f, second gets -f
  assign sub_sel = state_q == TS_WR2;
  assign upd_word = {
    sat_acc(mem_rdata[3*FORCEW-1:2*FORCEW], core_res.mag[2], core_res.neg[2] ^ sub_sel),
    sat_acc(mem_rdata[2*FORCEW-1:FORCEW],   core_res.mag[1], core_res.neg[1] ^ sub_sel),
    sat_acc(mem_rdata[FORCEW-1:0],          core_res.mag[0], core_res.neg[0] ^ sub_sel)
  };

  hbfa_core u_core (
    .clk_i,
    .rst_ni,
    .start_i           (core_start),
    .first_x_i,
    .first_y_i,
    .first_z_i,
    .second_x_i,
    .second_y_i,
    .second_z_i,
    .spring_constant_i (k_q),
    .rest_length_i     (rest_q),
    .done_o            (core_done),
    .res_o             (core_res)
  );

  hbfa_store #(.DEPTH(PARTICLES), .AW(AW)) u_store (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TS_CLEAR: if (clr_q == AW'(PARTICLES - 1)) state_d = TS_IDLE;
      TS_IDLE: begin
        if (accept) begin
          if (cmd_is_bond) begin
            state_d = TS_BOND;
          end else if (command_i == CMD_FORCE && in_rng_a) begin
            state_d = TS_FRD;
          end
        end
      end
      TS_BOND: if (core_done) state_d = TS_RD1;
      TS_RD1:  state_d = in_rng_1 ? TS_WR1 : TS_RD2;
      TS_WR1:  state_d = TS_RD2;
      TS_RD2:  state_d = in_rng_2 ? TS_WR2 : TS_IDLE;
      TS_WR2:  state_d = TS_IDLE;
      TS_FRD:  state_d = TS_IDLE;
      default: state_d = TS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = state_q != TS_IDLE;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = addr_a;
    unique case (state_q)
      TS_CLEAR: mem_we = 1'b1;
      TS_IDLE:  mem_re = accept && command_i == CMD_FORCE && in_rng_a;
      TS_BOND:  ;
      TS_RD1: begin
        mem_re    = in_rng_1;
        mem_raddr = addr_1;
      end
      TS_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = addr_1;
        mem_wdata = upd_word;
      end
      TS_RD2: begin
        mem_re    = in_rng_2;
        mem_raddr = addr_2;
      end
      TS_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = addr_2;
        mem_wdata = upd_word;
      end
      TS_FRD: begin
        mem_we    = 1'b1;
        mem_waddr = addr_1;
      end
      default: ;
    endcase
  end

  assign pready           = 1'b1;
  assign prdata           = paddr[2] ? rest_q : k_q;
  assign result_valid_o   = valid_q;
  assign particle_index_o = pidx_q;
  assign force_x_o        = fx_q;
  assign force_y_o        = fy_q;
  assign force_z_o        = fz_q;
  assign total_energy_o   = eout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= TS_CLEAR;
      clr_q    <= '0;
      valid_q  <= 1'b0;
      energy_q <= '0;
      k_q      <= CFGW'(65536);
      rest_q   <= CFGW'(65536);
    end else begin
      state_q <= state_d;
      if (state_q == TS_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      valid_q <= (accept && (command_i == CMD_ENERGY ||
                             (command_i == CMD_FORCE && !in_rng_a))) ||
                 state_q == TS_FRD;
      if (accept && command_i == CMD_ENERGY) begin
        energy_q <= '0;
      end else if (state_q == TS_BOND && core_done) begin
        energy_q <= en_sum[ENW] ? '1 : en_sum[ENW-1:0];
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2]) begin
          rest_q <= pwdata;
        end else begin
          k_q <= pwdata;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx1_q <= first_index_i;
      idx2_q <= second_index_i;
      if (command_i == CMD_ENERGY) begin
        pidx_q <= '0;
        fx_q   <= '0;
        fy_q   <= '0;
        fz_q   <= '0;
        eout_q <= energy_q;
      end else if (command_i == CMD_FORCE && !in_rng_a) begin
        pidx_q <= first_index_i;
        fx_q   <= '0;
        fy_q   <= '0;
        fz_q   <= '0;
        eout_q <= '0;
      end
    end
    if (state_q == TS_FRD) begin
      pidx_q <= idx1_q;
      fx_q   <= mem_rdata[FORCEW-1:0];
      fy_q   <= mem_rdata[2*FORCEW-1:FORCEW];
      fz_q   <= mem_rdata[3*FORCEW-1:2*FORCEW];
      eout_q <= '0;
    end
  end

endmodule

>>> dv/tb_top.sv
// self-checking testbench of the harmonic bond force accumulator
// drives commands and apb register writes, predicts every result, compares field by field
// depends on hbfa_pkg and the harmonic_bond_force_accumulator rtl
`timescale 1ns / 100ps

module tb_top;
  import hbfa_pkg::*;

  localparam int SETTLE = 800;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] ADDR_SPRING = 3'd0;
  localparam logic [2:0] ADDR_REST = 3'd4;
  localparam logic [47:0] EMAX = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [63:0] FPOS = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] FNEG = -64'sh0000_8000_0000_0000;

  typedef enum logic [1:0] {K_CMD, K_CFG, K_DRAIN} item_kind_e;
  typedef enum logic [1:0] {AP_IDLE, AP_SETUP, AP_ACCESS} apb_phase_e;

  typedef struct {
    item_kind_e  kind;
    cmd_e        cmd;
    logic [9:0]  ia;
    logic [9:0]  ib;
    logic [31:0] pos [6];
    logic [2:0]  addr;
    logic [31:0] val;
  } item_t;

  typedef struct {
    logic [9:0]  idx;
    logic [47:0] fx;
    logic [47:0] fy;
    logic [47:0] fz;
    logic [47:0] en;
  } readout_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] command_i = 2'd0;
  logic [9:0] first_index_i = '0;
  logic [9:0] second_index_i = '0;
  logic [31:0] first_x_i = '0, first_y_i = '0, first_z_i = '0;
  logic [31:0] second_x_i = '0, second_y_i = '0, second_z_i = '0;
  logic result_valid_o;
  logic [9:0] particle_index_o;
  logic [47:0] force_x_o, force_y_o, force_z_o, total_energy_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  harmonic_bond_force_accumulator u_dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .first_index_i, .second_index_i,
    .first_x_i, .first_y_i, .first_z_i, .second_x_i, .second_y_i, .second_z_i,
    .result_valid_o, .particle_index_o, .force_x_o, .force_y_o, .force_z_o,
    .total_energy_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [31:0] mdl_spring = 32'h0001_0000;
  logic [31:0] mdl_rest = 32'h0001_0000;
  logic signed [63:0] fmem [3][1024];
  logic [47:0] energy_acc = '0;

  item_t pend_q [$];
  readout_t readout_q [$];
  int errors = 0;
  int wd = 0;

  function automatic logic [63:0] root_floor(logic [127:0] v);
    logic [127:0] r, c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return r[63:0];
  endfunction

  function automatic logic signed [63:0] sat_force(logic signed [63:0] v);
    if (v > FPOS) return FPOS;
    if (v < FNEG) return FNEG;
    return v;
  endfunction

  task automatic predict_bond(item_t it);
    logic [32:0] dneg;
    logic [127:0] dm [3];
    logic [127:0] sq, prod, p, e, q, rm;
    logic [63:0] span;
    logic signed [63:0] r, f [3];
    logic [48:0] esum;
    sq = '0;
    for (int c = 0; c < 3; c++) begin
      dneg[c] = 1'b0;
    end
    for (int c = 0; c < 3; c++) begin
      logic [32:0] d;
      d = {it.pos[c][31], it.pos[c]} - {it.pos[c+3][31], it.pos[c+3]};
      dneg[c] = d[32];
      dm[c] = d[32] ? {95'd0, (~d) + 33'd1} : {95'd0, d};
      sq = sq + dm[c] * dm[c];
    end
    span = root_floor(sq);
    r = $signed(span) - $signed({32'd0, mdl_spring & 32'd0 | mdl_rest});
    rm = r[63] ? {64'd0, -r} : {64'd0, r};
    prod = {96'd0, mdl_spring} * rm;
    p = prod >> 16;
    prod = p * rm;
    e = prod >> 17;
    if (e > {80'd0, EMAX}) e = {80'd0, EMAX};
    esum = {1'b0, energy_acc} + {1'b0, e[47:0]};
    energy_acc = esum[48] ? EMAX : esum[47:0];
    for (int c = 0; c < 3; c++) begin
      f[c] = 0;
      if (span != 0) begin
        q = (p * dm[c]) / {64'd0, span};
        f[c] = (r[63] != dneg[c]) ? $signed(q[63:0]) : -$signed(q[63:0]);
      end
    end
    for (int c = 0; c < 3; c++) fmem[c][it.ia] = sat_force(fmem[c][it.ia] + f[c]);
    for (int c = 0; c < 3; c++) fmem[c][it.ib] = sat_force(fmem[c][it.ib] - f[c]);
  endtask

  task automatic predict_item(item_t it);
    readout_t ro;
    case (it.cmd)
      CMD_BOND: predict_bond(it);
      CMD_FORCE: begin
        ro.idx = it.ia;
        ro.fx = fmem[0][it.ia][47:0];
        ro.fy = fmem[1][it.ia][47:0];
        ro.fz = fmem[2][it.ia][47:0];
        ro.en = '0;
        for (int c = 0; c < 3; c++) fmem[c][it.ia] = 0;
        readout_q.push_back(ro);
      end
      CMD_ENERGY: begin
        ro = '{idx: '0, fx: '0, fy: '0, fz: '0, en: energy_acc};
        energy_acc = '0;
        readout_q.push_back(ro);
      end
      default: ;
    endcase
  endtask

  // driver
  item_t cur, nxt;
  apb_phase_e ap = AP_IDLE;
  int gap = 0;
  int quiet = 0;
  logic took;

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 0;
    if (sel < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 100);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      ap <= AP_IDLE;
      gap <= 0;
      quiet <= 0;
    end else begin
      took = start && !busy;
      if (took) begin
        predict_item(cur);
        quiet <= 0;
      end else if (quiet < SETTLE) begin
        quiet <= quiet + 1;
      end
      if (ap == AP_SETUP) begin
        penable <= 1'b1;
        ap <= AP_ACCESS;
      end else if (ap == AP_ACCESS) begin
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (pend_q[0].addr == ADDR_SPRING) mdl_spring = pend_q[0].val;
        else mdl_rest = pend_q[0].val;
        void'(pend_q.pop_front());
        ap <= AP_IDLE;
      end else if (start && !took) begin
        // hold the item until the block takes it
      end else if (gap != 0) begin
        start <= 1'b0;
        gap <= gap - 1;
      end else if (pend_q.size() == 0) begin
        start <= 1'b0;
      end else begin
        nxt = pend_q[0];
        case (nxt.kind)
          K_CMD: begin
            cur = nxt;
            command_i <= nxt.cmd;
            first_index_i <= nxt.ia;
            second_index_i <= nxt.ib;
            first_x_i <= nxt.pos[0];
            first_y_i <= nxt.pos[1];
            first_z_i <= nxt.pos[2];
            second_x_i <= nxt.pos[3];
            second_y_i <= nxt.pos[4];
            second_z_i <= nxt.pos[5];
            start <= 1'b1;
            void'(pend_q.pop_front());
            gap <= pick_gap();
          end
          K_DRAIN: begin
            start <= 1'b0;
            if (readout_q.size() == 0 && !busy && !took) void'(pend_q.pop_front());
          end
          default: begin
            start <= 1'b0;
            if (readout_q.size() == 0 && !busy && !took && quiet >= SETTLE) begin
              psel <= 1'b1;
              pwrite <= 1'b1;
              paddr <= nxt.addr;
              pwdata <= nxt.val;
              ap <= AP_SETUP;
            end
          end
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (readout_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result idx=%0d", particle_index_o);
      end else begin
        readout_t ex;
        ex = readout_q.pop_front();
        if (ex.idx !== particle_index_o || ex.fx !== force_x_o || ex.fy !== force_y_o ||
            ex.fz !== force_z_o || ex.en !== total_energy_o) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp idx=%0d f=%h %h %h e=%h got idx=%0d f=%h %h %h e=%h",
                     ex.idx, ex.fx, ex.fy, ex.fz, ex.en, particle_index_o,
                     force_x_o, force_y_o, force_z_o, total_energy_o);
        end
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (psel && penable)) wd <= 0;
    else wd <= wd + 1;
    if (wd >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // stimulus
  task automatic push_cmd(cmd_e cmd, logic [9:0] ia, logic [9:0] ib,
                          logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                          logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
    item_t it;
    it.kind = K_CMD;
    it.cmd = cmd;
    it.ia = ia;
    it.ib = ib;
    it.pos[0] = ax; it.pos[1] = ay; it.pos[2] = az;
    it.pos[3] = bx; it.pos[4] = by; it.pos[5] = bz;
    it.addr = '0;
    it.val = '0;
    pend_q.push_back(it);
  endtask

  task automatic push_cfg(logic [2:0] addr, logic [31:0] val);
    item_t it;
    it.kind = K_CFG;
    it.cmd = CMD_NONE;
    it.ia = '0;
    it.ib = '0;
    for (int c = 0; c < 6; c++) it.pos[c] = '0;
    it.addr = addr;
    it.val = val;
    pend_q.push_back(it);
  endtask

  task automatic push_drain();
    item_t it;
    it.kind = K_DRAIN;
    it.cmd = CMD_NONE;
    it.ia = '0;
    it.ib = '0;
    for (int c = 0; c < 6; c++) it.pos[c] = '0;
    it.addr = '0;
    it.val = '0;
    pend_q.push_back(it);
  endtask

  function automatic logic [31:0] pick_edge_value();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic push_random();
    int sel, shape;
    cmd_e cmd;
    logic [9:0] ia, ib;
    logic [31:0] a [3], b [3];
    sel = $urandom_range(0, 99);
    cmd = sel < 60 ? CMD_BOND : sel < 85 ? CMD_FORCE : sel < 95 ? CMD_ENERGY : CMD_NONE;
    ia = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, 15)) : 10'($urandom);
    ib = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, 15)) : 10'($urandom);
    shape = $urandom_range(0, 99);
    for (int c = 0; c < 3; c++) begin
      if (shape < 70) begin
        a[c] = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        b[c] = a[c] + ($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      end else if (shape < 85) begin
        a[c] = $urandom;
        b[c] = $urandom;
      end else if (shape < 95) begin
        a[c] = $urandom;
        b[c] = a[c];
      end else begin
        a[c] = pick_edge_value();
        b[c] = pick_edge_value();
      end
    end
    push_cmd(cmd, ia, ib, a[0], a[1], a[2], b[0], b[1], b[2]);
  endtask

  initial begin
    for (int c = 0; c < 3; c++)
      for (int i = 0; i < 1024; i++) fmem[c][i] = 0;

    // defaults: zero distance, axis bond, extreme span, self bond, edge indices, reads
    push_cmd(CMD_BOND, 10'd1, 10'd2, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000,
             32'h0003_0000, 32'h0003_0000, 32'h0003_0000);
    push_cmd(CMD_BOND, 10'd1, 10'd2, 32'h0002_8000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_cmd(CMD_BOND, 10'd3, 10'd4, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    push_cmd(CMD_BOND, 10'd5, 10'd5, 32'h0000_4000, 32'hFFFF_0000, 32'h1, 32'h0, 32'h0, 32'h0);
    push_cmd(CMD_BOND, 10'd1023, 10'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_cmd(CMD_NONE, 10'd1, 10'd2, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    for (int i = 0; i < 6; i++)
      push_cmd(CMD_FORCE, 10'(i), 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_cmd(CMD_FORCE, 10'd1023, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_cmd(CMD_ENERGY, 10'd7, 10'd9, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_cmd(CMD_ENERGY, 10'd0, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);

    // stiffest spring, zero rest length: saturate forces and energy
    push_cfg(ADDR_SPRING, 32'hFFFF_FFFF);
    push_cfg(ADDR_REST, 32'h0);
    for (int i = 0; i < 4; i++)
      push_cmd(CMD_BOND, 10'd6, 10'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_cmd(CMD_FORCE, 10'd6, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_cmd(CMD_FORCE, 10'd7, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_cmd(CMD_ENERGY, 10'd0, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);

    // no spring, longest rest length
    push_cfg(ADDR_SPRING, 32'h0);
    push_cfg(ADDR_REST, 32'hFFFF_FFFF);
    push_cmd(CMD_BOND, 10'd8, 10'd9, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_cmd(CMD_FORCE, 10'd8, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    push_cmd(CMD_ENERGY, 10'd0, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);

    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) begin
        push_cfg(ADDR_SPRING, $urandom);
        push_cfg(ADDR_REST, $urandom);
      end else begin
        push_cfg(ADDR_SPRING, $urandom_range(32'h0000_1000, 32'h0010_0000));
        push_cfg(ADDR_REST, $urandom_range(0, 32'h0008_0000));
      end
      for (int i = 0; i < 270; i++) begin
        push_random();
        if ($urandom_range(0, 99) == 0) push_drain();
      end
      push_drain();
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pend_q.size() == 0 && !start && ap == AP_IDLE && readout_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0 && readout_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/hbfa_pkg.sv
sv/hbfa_store.sv
sv/hbfa_core.sv
sv/harmonic_bond_force_accumulator.sv
dv/tb_top.sv
